// File: rtl/core/slcs_pkg.sv
// Shared types and codes for the source lexer block.
// No dependencies; every other file of the block imports this package.
package slcs_pkg;

  // Default storage depths, handed to the top level as parameter defaults.
  localparam int QUEUE_DEPTH_DEF  = 2;
  localparam int RESULT_DEPTH_DEF = 4;

  // Byte classes found by the front part.
  localparam logic [2:0] CLS_SPACE = 3'd0;
  localparam logic [2:0] CLS_ALPHA = 3'd1;
  localparam logic [2:0] CLS_DIGIT = 3'd2;
  localparam logic [2:0] CLS_QUOTE = 3'd3;
  localparam logic [2:0] CLS_DBL   = 3'd4;
  localparam logic [2:0] CLS_OP    = 3'd5;
  localparam logic [2:0] CLS_CTRL  = 3'd6;
  localparam logic [2:0] CLS_OTHER = 3'd7;

  // Lexer modes of the back part.
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_IDENT  = 3'd1;
  localparam logic [2:0] MODE_NUMBER = 3'd2;
  localparam logic [2:0] MODE_STRING = 3'd3;
  localparam logic [2:0] MODE_ESCAPE = 3'd4;
  localparam logic [2:0] MODE_OP     = 3'd5;
  localparam logic [2:0] MODE_DOUBLE = 3'd6;

  // Token kinds as they appear on the result word.
  localparam logic [2:0] KIND_IDENT  = 3'd0;
  localparam logic [2:0] KIND_NUMBER = 3'd1;
  localparam logic [2:0] KIND_STRING = 3'd2;
  localparam logic [2:0] KIND_OP     = 3'd3;
  localparam logic [2:0] KIND_DBL    = 3'd4;
  localparam logic [2:0] KIND_CTRL   = 3'd5;
  localparam logic [2:0] KIND_OTHER  = 3'd6;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic       has_char;
    logic [7:0] char_out;
    logic       token_done;
    logic [2:0] token_kind;
    logic       stream_end;
    logic       last;
  } out_item_t;

  // A byte after classification, as it waits between front and back.
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic [2:0] cls;
    logic       is_dot;
    logic       is_eq;
    logic       is_bslash;
  } cls_item_t;

endpackage

// File: rtl/core/slcs_front.sv
// Front part of the source lexer: accepts input words and classifies each byte.
// Depends on slcs_pkg; feeds slcs_queue.
module slcs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  slcs_pkg::in_item_t  in_data,
  input  logic                q_full,
  output logic                q_push,
  output slcs_pkg::cls_item_t q_data
);
  import slcs_pkg::*;

  logic [7:0] ch;
  logic       acc_seen_r;
  logic       acc_seen_nxt;

  assign ch     = in_data.char_in;
  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_data           = '0;
    q_data.ch        = ch;
    q_data.eoi       = in_data.end_of_input;
    q_data.is_dot    = (ch == 8'h2E);
    q_data.is_eq     = (ch == 8'h3D);
    q_data.is_bslash = (ch == 8'h5C);
    unique case (ch) inside
      8'h20, [8'h09:8'h0D]:                     q_data.cls = CLS_SPACE;
      [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F:      q_data.cls = CLS_ALPHA;
      [8'h30:8'h39]:                            q_data.cls = CLS_DIGIT;
      8'h22, 8'h27:                             q_data.cls = CLS_QUOTE;
      8'h7C, 8'h26, 8'h2B, 8'h2D:               q_data.cls = CLS_DBL;
      8'h3C, 8'h3E, 8'h21, 8'h3D, 8'h2A, 8'h2F: q_data.cls = CLS_OP;
      8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D,
      8'h3B, 8'h2C, 8'h2E:                      q_data.cls = CLS_CTRL;
      default:                                  q_data.cls = CLS_OTHER;
    endcase
  end

  // Marks that a word has been taken since reset; used by the checks below.
  assign acc_seen_nxt = acc_seen_r || q_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_seen_r <= 1'b0;
    end else begin
      acc_seen_r <= acc_seen_nxt;
    end
  end

`ifndef SYNTHESIS
  a_push_gated: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push) else $error("word pushed into a full queue");
  a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(q_push) |-> acc_seen_r) else $error("accept marker lost");
  a_class_eoi: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_data.eoi == in_data.end_of_input))
    else $error("end mark not carried");
`endif

endmodule

// File: rtl/core/slcs_queue.sv
// Short queue of classified bytes between the front and back parts.
// Depends on slcs_pkg for the entry type.
module slcs_queue #(
  parameter int DEPTH = slcs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  slcs_pkg::cls_item_t wr_data,
  output logic                full,
  input  logic                rd_en,
  output slcs_pkg::cls_item_t rd_data,
  output logic                empty
);
  import slcs_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cls_item_t          mem_r [DEPTH];
  logic [IDX_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(wr_en) - CNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/core/slcs_engine.sv
// Back part of the source lexer: runs the token state machine on classified
// bytes and buffers up to two result words per byte. Depends on slcs_pkg.
module slcs_engine #(
  parameter int RDEPTH = slcs_pkg::RESULT_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  slcs_pkg::cls_item_t  q_data,
  output logic                 q_pop,
  input  logic                 pop,
  output logic                 empty,
  output slcs_pkg::out_item_t  out_data
);
  import slcs_pkg::*;

  localparam int IDX_W = $clog2(RDEPTH);
  localparam int CNT_W = $clog2(RDEPTH + 1);

  logic [2:0]       mode_r, mode_nxt;
  logic [7:0]       match_r, match_nxt;
  out_item_t        res_mem_r [RDEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt, wr1_ptr, wr2_ptr;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             out_pop;
  logic             st_valid, st_setm;
  logic [2:0]       st_mode;
  out_item_t        st_res, cl_res, r0, r1;
  logic [1:0]       n_res, n_wr;
  logic             close_start, do_start;

  function automatic logic [2:0] mode_kind(input logic [2:0] m);
    logic [2:0] k;
    unique case (m)
      MODE_NUMBER:              k = KIND_NUMBER;
      MODE_STRING, MODE_ESCAPE: k = KIND_STRING;
      MODE_OP:                  k = KIND_OP;
      MODE_DOUBLE:              k = KIND_DBL;
      default:                  k = KIND_IDENT;
    endcase
    return k;
  endfunction

  function automatic out_item_t mk_res(input logic has, input logic [7:0] ch,
                                       input logic done, input logic [2:0] kind,
                                       input logic fin);
    out_item_t r;
    r            = '0;
    r.has_char   = has;
    r.char_out   = has ? ch : 8'h00;
    r.token_done = done;
    r.token_kind = kind;
    r.stream_end = fin;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] inc_ptr(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(RDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // A byte is taken only when two result slots are free.
  assign q_pop   = !q_empty && (cnt_r <= CNT_W'(RDEPTH - 2));
  assign empty   = (cnt_r == '0);
  assign out_pop = pop && !empty;
  assign out_data = res_mem_r[rd_ptr_r];

  // Result of opening a token with the current byte.
  always_comb begin
    st_valid = 1'b1;
    st_setm  = 1'b0;
    st_mode  = MODE_IDLE;
    st_res   = mk_res(1'b1, q_data.ch, 1'b0, KIND_IDENT, 1'b0);
    unique case (q_data.cls)
      CLS_SPACE: st_valid = 1'b0;
      CLS_ALPHA: st_mode  = MODE_IDENT;
      CLS_DIGIT: begin
        st_mode = MODE_NUMBER;
        st_res  = mk_res(1'b1, q_data.ch, 1'b0, KIND_NUMBER, 1'b0);
      end
      CLS_QUOTE: begin
        st_mode = MODE_STRING;
        st_setm = 1'b1;
        st_res  = mk_res(1'b1, q_data.ch, 1'b0, KIND_STRING, 1'b0);
      end
      CLS_DBL: begin
        st_mode = MODE_DOUBLE;
        st_setm = 1'b1;
        st_res  = mk_res(1'b1, q_data.ch, 1'b0, KIND_DBL, 1'b0);
      end
      CLS_OP: begin
        st_mode = MODE_OP;
        st_res  = mk_res(1'b1, q_data.ch, 1'b0, KIND_OP, 1'b0);
      end
      CLS_CTRL:  st_res = mk_res(1'b1, q_data.ch, 1'b1, KIND_CTRL, 1'b0);
      default:   st_res = mk_res(1'b1, q_data.ch, 1'b1, KIND_OTHER, 1'b0);
    endcase
  end

  // Main token state machine.
  always_comb begin
    cl_res      = mk_res(1'b0, 8'h00, 1'b1, mode_kind(mode_r), 1'b0);
    r0          = st_res;
    r1          = '0;
    n_res       = 2'd0;
    mode_nxt    = mode_r;
    match_nxt   = match_r;
    close_start = 1'b0;
    do_start    = 1'b0;
    if (q_data.eoi) begin
      r0       = mk_res(1'b0, 8'h00, (mode_r != MODE_IDLE),
                        (mode_r != MODE_IDLE) ? mode_kind(mode_r) : KIND_IDENT, 1'b1);
      n_res    = 2'd1;
      mode_nxt = MODE_IDLE;
    end else begin
      unique case (mode_r)
        MODE_IDENT: begin
          if (q_data.cls == CLS_ALPHA || q_data.cls == CLS_DIGIT) begin
            r0    = mk_res(1'b1, q_data.ch, 1'b0, KIND_IDENT, 1'b0);
            n_res = 2'd1;
          end else begin
            close_start = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (q_data.cls == CLS_DIGIT || q_data.is_dot) begin
            r0    = mk_res(1'b1, q_data.ch, 1'b0, KIND_NUMBER, 1'b0);
            n_res = 2'd1;
          end else begin
            close_start = 1'b1;
          end
        end
        MODE_STRING: begin
          if (q_data.is_bslash) begin
            mode_nxt = MODE_ESCAPE;
          end else if (q_data.ch == match_r) begin
            r0       = cl_res;
            n_res    = 2'd1;
            mode_nxt = MODE_IDLE;
          end else begin
            r0    = mk_res(1'b1, q_data.ch, 1'b0, KIND_STRING, 1'b0);
            n_res = 2'd1;
          end
        end
        MODE_ESCAPE: begin
          r0       = mk_res(1'b1, q_data.ch, 1'b0, KIND_STRING, 1'b0);
          n_res    = 2'd1;
          mode_nxt = MODE_STRING;
        end
        MODE_OP: begin
          if (q_data.is_eq) begin
            r0       = mk_res(1'b1, q_data.ch, 1'b1, KIND_OP, 1'b0);
            n_res    = 2'd1;
            mode_nxt = MODE_IDLE;
          end else begin
            close_start = 1'b1;
          end
        end
        MODE_DOUBLE: begin
          if (q_data.ch == match_r) begin
            r0       = mk_res(1'b1, q_data.ch, 1'b1, KIND_DBL, 1'b0);
            n_res    = 2'd1;
            mode_nxt = MODE_IDLE;
          end else begin
            close_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase
      if (close_start) begin
        r0        = cl_res;
        r1        = st_res;
        n_res     = st_valid ? 2'd2 : 2'd1;
        mode_nxt  = st_mode;
        match_nxt = st_setm ? q_data.ch : match_r;
      end else if (do_start) begin
        n_res     = st_valid ? 2'd1 : 2'd0;
        mode_nxt  = st_mode;
        match_nxt = st_setm ? q_data.ch : match_r;
      end
    end
    if (n_res == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n_res == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  // Result buffer bookkeeping.
  always_comb begin
    n_wr       = q_pop ? n_res : 2'd0;
    wr1_ptr    = inc_ptr(wr_ptr_r);
    wr2_ptr    = inc_ptr(wr1_ptr);
    wr_ptr_nxt = (n_wr == 2'd2) ? wr2_ptr : (n_wr == 2'd1) ? wr1_ptr : wr_ptr_r;
    rd_ptr_nxt = out_pop ? inc_ptr(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(n_wr) - CNT_W'(out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      match_r  <= 8'h00;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_pop) begin
        mode_r  <= mode_nxt;
        match_r <= match_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      res_mem_r[wr_ptr_r] <= r0;
    end
    if (n_wr == 2'd2) begin
      res_mem_r[wr1_ptr] <= r1;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(RDEPTH)) else $error("result buffer overfilled");
  a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_data.eoi) |=> (mode_r == MODE_IDLE))
    else $error("end of input left a token open");
  a_escape_from_string: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ESCAPE && $past(rst_n)) |-> ($past(mode_r) == MODE_STRING ||
                                                 $past(mode_r) == MODE_ESCAPE))
    else $error("escape mode entered outside a string");
`endif

endmodule

// File: rtl/core/source_lexer_char_step.sv
// Top level of the source lexer: joins the classifying front, the byte queue
// and the token engine. Depends on slcs_pkg, slcs_front, slcs_queue, slcs_engine.
//
// The block cuts a byte stream into tokens. Each input word carries one source
// byte or an end-of-input mark; each result word carries one lexeme byte
// (has_char), an end-of-token mark with the token's kind, or the end-of-stream
// answer, and last flags the final word caused by an input word. A byte that
// ends one token and starts the next gives two words; whitespace between
// tokens, and a backslash inside a string, give none, and whitespace that ends
// a token gives only the closing word. The front classifies a byte in the
// cycle it is accepted and writes it into a short queue; the engine takes one
// byte a cycle from that queue whenever two result slots are free and writes
// its words into the result buffer, which delivers one word a cycle. An input
// word is accepted every cycle while the queue has room, so a stream of bytes
// giving one word each runs at one byte per cycle; bytes giving two words are
// held to the output rate of one word per cycle. An accepted byte is first
// registered in the queue and then its words in the result buffer, which
// drives the result ports directly. Both sides may stall freely: full
// depends only on the queue fill and empty only on the result buffer fill.
// There is no configuration and no clearing pass after reset.
module source_lexer_char_step #(
  parameter int QUEUE_DEPTH  = slcs_pkg::QUEUE_DEPTH_DEF,
  parameter int RESULT_DEPTH = slcs_pkg::RESULT_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  slcs_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output slcs_pkg::out_item_t out_data
);
  import slcs_pkg::*;

  // Classified bytes travelling from the front into the queue and on to the
  // engine.
  cls_item_t q_wr_data;
  cls_item_t q_rd_data;
  logic      q_wr_en;
  logic      q_full;
  logic      q_rd_en;
  logic      q_empty;

  // The front takes a word whenever the queue is not full.
  slcs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_wr_en),
    .q_data  (q_wr_data)
  );

  // The queue lets the front keep accepting while the engine waits for room
  // in the result buffer.
  slcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // The engine holds the lexer state and the result buffer that drives the
  // output side.
  slcs_engine #(
    .RDEPTH (RESULT_DEPTH)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rd_data),
    .q_pop    (q_rd_en),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule
